### design/v3n_pkg.sv
// v3n_pkg: shared widths for vector3_normalize.
// No dependencies.
`timescale 1ns / 1ps
package v3n_pkg;
   localparam int CompWidth = 32;
   localparam int MagWidth  = 32;
   localparam int SumWidth  = 64;
   localparam int RootWidth = 32;
   localparam int FracBits  = 30;
   localparam int DivWidth  = MagWidth + FracBits;   // dividend width, 62 bits
   localparam int ReqWidth  = 3 * CompWidth;
   localparam int RspWidth  = 4 * CompWidth;
endpackage

### design/v3n_sqrt.sv
// v3n_sqrt: pipelined digit-by-digit integer square root, one result bit per stage.
// Depends on v3n_pkg. Carries three magnitudes and signs beside the root.
`timescale 1ns / 1ps
module v3n_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [v3n_pkg::SumWidth-1:0]   in_sum,
   input  logic [3*v3n_pkg::MagWidth-1:0] in_mag,
   input  logic [2:0]                     in_neg,
   output logic                           out_valid,
   output logic [v3n_pkg::RootWidth-1:0]  out_root,
   output logic [3*v3n_pkg::MagWidth-1:0] out_mag,
   output logic [2:0]                     out_neg
);
   import v3n_pkg::*;
   localparam int Steps = RootWidth;

   logic                          valid_ff [1:Steps];
   logic [SumWidth-1:0]           rem_ff   [1:Steps];
   logic [SumWidth-1:0]           rad_ff   [1:Steps];
   logic [RootWidth-1:0]          root_ff  [1:Steps];
   logic [3*MagWidth-1:0]         mag_ff   [1:Steps];
   logic [2:0]                    neg_ff   [1:Steps];

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic                  cur_valid;
      logic [SumWidth-1:0]   cur_rem;
      logic [SumWidth-1:0]   cur_rad;
      logic [RootWidth-1:0]  cur_root;
      logic [3*MagWidth-1:0] cur_mag;
      logic [2:0]            cur_neg;
      logic [SumWidth+1:0] trial_in;
      logic [SumWidth+1:0] rem2;
      logic [SumWidth+1:0] rem_in;
      logic [RootWidth-1:0] root_in;
      if (s == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_rem   = '0;
         assign cur_rad   = in_sum;
         assign cur_root  = '0;
         assign cur_mag   = in_mag;
         assign cur_neg   = in_neg;
      end else begin : g_next
         assign cur_valid = valid_ff[s];
         assign cur_rem   = rem_ff[s];
         assign cur_rad   = rad_ff[s];
         assign cur_root  = root_ff[s];
         assign cur_mag   = mag_ff[s];
         assign cur_neg   = neg_ff[s];
      end
      always_comb begin
         rem2     = {cur_rem, cur_rad[SumWidth-1 -: 2]};
         trial_in = {{(SumWidth-RootWidth){1'b0}}, cur_root, 2'b01};
         if (rem2 >= trial_in) begin
            rem_in  = rem2 - trial_in;
            root_in = {cur_root[RootWidth-2:0], 1'b1};
         end else begin
            rem_in  = rem2;
            root_in = {cur_root[RootWidth-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= cur_valid;
         end
         if (advance) begin
            rem_ff[s+1]  <= rem_in[SumWidth-1:0];
            rad_ff[s+1]  <= {cur_rad[SumWidth-3:0], 2'b00};
            root_ff[s+1] <= root_in;
            mag_ff[s+1]  <= cur_mag;
            neg_ff[s+1]  <= cur_neg;
         end
      end
   end

   assign out_valid = valid_ff[Steps];
   assign out_root  = root_ff[Steps];
   assign out_mag   = mag_ff[Steps];
   assign out_neg   = neg_ff[Steps];
endmodule

### design/v3n_div.sv
// v3n_div: three pipelined restoring dividers, (mag << 30) / root, one quotient bit per stage.
// Depends on v3n_pkg. Applies signs and the zero case at the output.
`timescale 1ns / 1ps
module v3n_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [v3n_pkg::RootWidth-1:0]  in_root,
   input  logic [3*v3n_pkg::MagWidth-1:0] in_mag,
   input  logic [2:0]                     in_neg,
   output logic                           out_valid,
   output logic [v3n_pkg::RspWidth:0]     out_data
);
   import v3n_pkg::*;
   localparam int Steps = DivWidth;

   logic                  valid_ff [1:Steps];
   logic [RootWidth-1:0]  den_ff [1:Steps];
   logic [2:0]            neg_ff [1:Steps];
   logic [RootWidth:0]    rem_ff [1:Steps][3];
   logic [DivWidth-1:0]   quo_ff [1:Steps][3];

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic                 cur_valid;
      logic [RootWidth-1:0] cur_den;
      logic [2:0]           cur_neg;
      if (s == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_den   = in_root;
         assign cur_neg   = in_neg;
      end else begin : g_next
         assign cur_valid = valid_ff[s];
         assign cur_den   = den_ff[s];
         assign cur_neg   = neg_ff[s];
      end
      for (genvar k = 0; k < 3; k++) begin : g_lane
         logic [RootWidth:0]   cur_rem;
         logic [DivWidth-1:0]  cur_quo;
         logic [RootWidth+1:0] shifted;
         logic [RootWidth+1:0] diff;
         logic [RootWidth:0]   rem_in;
         logic                 bit_in;
         if (s == 0) begin : g_first
            assign cur_rem = '0;
            assign cur_quo = {in_mag[k*MagWidth +: MagWidth], {FracBits{1'b0}}};
         end else begin : g_next
            assign cur_rem = rem_ff[s][k];
            assign cur_quo = quo_ff[s][k];
         end
         always_comb begin
            shifted = {cur_rem, cur_quo[DivWidth-1]};
            diff    = shifted - {2'b00, cur_den};
            bit_in  = !diff[RootWidth+1];
            rem_in  = bit_in ? diff[RootWidth:0] : shifted[RootWidth:0];
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[s+1][k] <= rem_in;
               quo_ff[s+1][k] <= {cur_quo[DivWidth-2:0], bit_in};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[s+1] <= cur_valid;
         end
         if (advance) begin
            den_ff[s+1] <= cur_den;
            neg_ff[s+1] <= cur_neg;
         end
      end
   end

   logic is_zero;
   logic [CompWidth-1:0] unit [3];
   always_comb begin
      is_zero = (den_ff[Steps] == '0);
      for (int k = 0; k < 3; k++) begin
         unit[k] = quo_ff[Steps][k][CompWidth-1:0];
         if (is_zero) begin
            unit[k] = '0;
         end else if (neg_ff[Steps][k]) begin
            unit[k] = '0 - unit[k];
         end
      end
   end

   assign out_valid = valid_ff[Steps];
   assign out_data  = {is_zero, den_ff[Steps], unit[2], unit[1], unit[0]};
endmodule

### design/vector3_normalize.sv
// vector3_normalize: 3D vector normalization, Q16.16 in, Q2.30 unit vector and Q16.16 length out.
// Depends on v3n_pkg, v3n_sqrt, v3n_div.
//
//   channel | direction | tdata (low bit up)                          | tuser
//   req     | in        | comp_x, comp_y, comp_z                      | -
//   rsp     | out       | unit_x, unit_y, unit_z, vec_length, is_zero | -
//
// One vector per cycle unless the output stalls. Path: front registers, the
// digit-serial square root and restoring divider pipelines, output register.
// Synchronous reset clears all valid bits. A stalled output holds the whole
// pipeline; the output register is taken again while it drains.
`timescale 1ns / 1ps
module vector3_normalize (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [v3n_pkg::ReqWidth-1:0]  req_tdata,  // comp_x, comp_y, comp_z
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [v3n_pkg::RspWidth+7:0]  rsp_tdata   // unit_x, unit_y, unit_z, vec_length,
                                                     // is_zero, zero fill
);
   import v3n_pkg::*;

   logic advance;
   logic rsp_valid_ff;
   logic [RspWidth:0] rsp_data_ff;

   // stage 1: magnitudes
   logic                  s1_valid_ff;
   logic [MagWidth-1:0]   s1_mag_ff [3];
   logic [2:0]            s1_neg_ff;
   // stage 2: squares, summed into stage 3
   logic                  s2_valid_ff;
   logic [SumWidth-1:0]   sq_ff [3];
   logic [3*MagWidth-1:0] s2_mag_ff;
   logic [2:0]            s2_neg_ff;
   logic                  s3_valid_ff;
   logic [SumWidth-1:0]   s3_sum_ff;
   logic [3*MagWidth-1:0] s3_mag_ff;
   logic [2:0]            s3_neg_ff;

   logic                  sq_valid;
   logic [RootWidth-1:0]  sq_root;
   logic [3*MagWidth-1:0] sq_mag;
   logic [2:0]            sq_neg;
   logic                  dv_valid;
   logic [RspWidth:0]     dv_data;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            s1_neg_ff[k] <= req_tdata[k*CompWidth + CompWidth-1];
            s1_mag_ff[k] <= req_tdata[k*CompWidth + CompWidth-1]
                            ? MagWidth'(0) - req_tdata[k*CompWidth +: CompWidth]
                            : req_tdata[k*CompWidth +: CompWidth];
            sq_ff[k] <= SumWidth'(s1_mag_ff[k]) * SumWidth'(s1_mag_ff[k]);
            s2_mag_ff[k*MagWidth +: MagWidth] <= s1_mag_ff[k];
         end
         s2_neg_ff <= s1_neg_ff;
         s3_sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         s3_mag_ff <= s2_mag_ff;
         s3_neg_ff <= s2_neg_ff;
      end
   end

   v3n_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s3_valid_ff),
      .in_sum    (s3_sum_ff),
      .in_mag    (s3_mag_ff),
      .in_neg    (s3_neg_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_mag   (sq_mag),
      .out_neg   (sq_neg)
   );

   v3n_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_mag    (sq_mag),
      .in_neg    (sq_neg),
      .out_valid (dv_valid),
      .out_data  (dv_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
      if (advance) begin
         rsp_data_ff <= dv_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff};
endmodule

### tb/tb_vector3_normalize.sv
// tb_vector3_normalize: self-checking bench for vector3_normalize, with an in-bench
// normalization predictor, a queued stream driver, a stalling monitor and a watchdog.
// Depends on v3n_pkg and the vector3_normalize RTL.
`timescale 1ns / 1ps
module tb_vector3_normalize;
   import v3n_pkg::*;

   localparam int LatencyCycles = 2 + 32 + 62 + 4;
   localparam int WatchdogLimit = 20000;
   localparam int RandomCount   = 1030;

   typedef struct packed {
      logic signed [31:0] comp_z;
      logic signed [31:0] comp_y;
      logic signed [31:0] comp_x;
   } vec_type;

   typedef struct packed {
      logic [6:0]         fill;
      logic               is_zero;
      logic [31:0]        vec_length;
      logic signed [31:0] unit_z;
      logic signed [31:0] unit_y;
      logic signed [31:0] unit_x;
   } unit_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [ReqWidth-1:0]    req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RspWidth+7:0]    rsp_tdata;

   vec_type  pending_vecs[$];
   unit_type expected_units[$];
   int    error_count;
   int    zero_count;
   int    checked_count;
   int    idle_cycles;
   bit    stimulus_done;
   bit    hold_sender;
   bit    long_stall;
   int    burst_left;
   int    gap_left;
   int    stall_phase;

   vector3_normalize DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic logic [63:0] floor_sqrt(input logic [63:0] value);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitpos;
      rem    = value;
      root   = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > value) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (rem >= root + bitpos) begin
            rem  = rem - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   function automatic unit_type normalize_vec(input vec_type v);
      logic [31:0] comps[3];
      logic [63:0] mags[3];
      logic [63:0] sum;
      logic [63:0] len;
      logic [63:0] quo;
      logic [31:0] res[3];
      unit_type    u;
      comps[0] = v.comp_x;
      comps[1] = v.comp_y;
      comps[2] = v.comp_z;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         mags[i] = comps[i][31] ? {32'd0, -comps[i]} : {32'd0, comps[i]};
         if (comps[i] == 32'h8000_0000) mags[i] = 64'h8000_0000;
         sum = sum + mags[i] * mags[i];
      end
      u = '0;
      if (sum == 0) begin
         u.is_zero = 1'b1;
         return u;
      end
      len = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         quo = (mags[i] << 30) / len;
         if (comps[i][31]) quo = -quo;
         res[i] = quo[31:0];
      end
      u.unit_x     = res[0];
      u.unit_y     = res[1];
      u.unit_z     = res[2];
      u.vec_length = len[31:0];
      return u;
   endfunction

   function automatic logic [31:0] random_comp();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 255) - 128;
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         3: return $urandom & 32'h0000_FFFF;
         4: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_vec(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
      vec_type v;
      v.comp_x = x;
      v.comp_y = y;
      v.comp_z = z;
      pending_vecs.push_back(v);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      stimulus_done = 1'b0;
      hold_sender   = 1'b0;
      push_vec(32'd0, 32'd0, 32'd0);
      push_vec(32'h8000_0000, 32'd0, 32'd0);
      push_vec(32'd0, 32'h8000_0000, 32'd0);
      push_vec(32'd0, 32'd0, 32'h8000_0000);
      push_vec(32'h7FFF_FFFF, 32'd0, 32'd0);
      push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      push_vec(32'd1, 32'd0, 32'd0);
      push_vec(32'd0, 32'hFFFF_FFFF, 32'd0);
      push_vec(32'd0, 32'd0, 32'd1);
      push_vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      push_vec(32'h0003_0000, 32'hFFFC_0000, 32'd0);
      push_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_vec(32'd1, 32'd1, 32'd1);
      push_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
      for (int i = 0; i < RandomCount; i++) begin
         if (i == RandomCount / 2) begin
            wait (pending_vecs.size() == 0);
            hold_sender = 1'b1;
            wait (expected_units.size() == 0);
            hold_sender = 1'b0;
         end
         push_vec(random_comp(), random_comp(), random_comp());
      end
      stimulus_done = 1'b1;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_units.push_back(normalize_vec(vec_type'(req_tdata)));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_vecs.size() > 0 && !hold_sender) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_vecs.pop_front();
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_phase <= 0;
         long_stall  <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_units.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_tdata);
               error_count++;
            end else begin
               unit_type want;
               unit_type got;
               want = expected_units.pop_front();
               got  = unit_type'(rsp_tdata);
               if (got.unit_x !== want.unit_x)
                  $display("%0t: unit_x expected %h actual %h", $time, want.unit_x, got.unit_x);
               if (got.unit_y !== want.unit_y)
                  $display("%0t: unit_y expected %h actual %h", $time, want.unit_y, got.unit_y);
               if (got.unit_z !== want.unit_z)
                  $display("%0t: unit_z expected %h actual %h", $time, want.unit_z, got.unit_z);
               if (got.vec_length !== want.vec_length)
                  $display("%0t: vec_length expected %h actual %h", $time,
                           want.vec_length, got.vec_length);
               if (got.is_zero !== want.is_zero)
                  $display("%0t: is_zero expected %b actual %b", $time,
                           want.is_zero, got.is_zero);
               if (got[127:0] !== want[127:0] || got.is_zero !== want.is_zero)
                  error_count++;
               if (want.is_zero) zero_count++;
               checked_count++;
            end
         end
         stall_phase <= stall_phase + 1;
         if (stall_phase >= 300 && stall_phase < 600) begin
            rsp_tready <= 1'b0;
            long_stall <= 1'b1;
         end else if (stall_phase < 800) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ((stall_phase % 7) < 3) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if (stall_phase >= 1400) stall_phase <= 600;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      error_count   = 0;
      zero_count    = 0;
      checked_count = 0;
      idle_cycles   = 0;
      fork
         begin
            wait (stimulus_done && pending_vecs.size() == 0 && !req_tvalid
                  && expected_units.size() == 0);
            repeat (LatencyCycles) @(posedge clock);
            if (expected_units.size() != 0) error_count++;
            $display("Checked %0d vectors, %0d zero, with extreme and random components,",
                     checked_count, zero_count);
            $display("long output stall seen: %0b, sender drained once mid-run.", long_stall);
            if (error_count == 0)
               $display("PASSED: all results match");
            else
               $display("FAILED: results differ");
            $finish;
         end
         begin
            wait (idle_cycles >= WatchdogLimit);
            $display("Watchdog expired with %0d results outstanding", expected_units.size());
            $display("FAILED: results differ");
            $finish;
         end
      join
   end
endmodule

### filelist.f
design/v3n_pkg.sv
design/v3n_sqrt.sv
design/v3n_div.sv
design/vector3_normalize.sv
tb/tb_vector3_normalize.sv
